>>> hdl/adsr_pkg.sv
package adsr_pkg;

   localparam int SampleBitsDefault = 16;
   localparam int CountBitsDefault  = 24;

   localparam int GainBits  = 32;   // unsigned Q2.30
   localparam int GainFrac  = 30;
   localparam int CsrAddrW  = 5;    // 8 registers, 4 bytes apart
   localparam int CsrDataW  = 32;

   localparam logic [GainBits-1:0] UnityGain = 32'h4000_0000;

   typedef enum logic [2:0] {
      PH_ATTACK  = 3'd0,
      PH_DECAY   = 3'd1,
      PH_SUSTAIN = 3'd2,
      PH_RELEASE = 3'd3,
      PH_DONE    = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      CSR_ATTACK_SAMPLES  = 3'd0,
      CSR_DECAY_SAMPLES   = 3'd1,
      CSR_SUSTAIN_SAMPLES = 3'd2,
      CSR_PEAK_LEVEL      = 3'd3,
      CSR_HOLD_LEVEL      = 3'd4,
      CSR_RISE_STEP       = 3'd5,
      CSR_FALL_STEP       = 3'd6,
      CSR_FADE_STEP       = 3'd7
   } csr_index_type;

endpackage

>>> hdl/adsr_envelope_gain.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_sample_in, req_note_start
// rsp       out        rsp_valid/rsp_stall   rsp_sample_out, rsp_phase_now
// csr       in/out     APB-style, pready=1   attack/decay/sustain lengths, levels, steps
//
// Two register stages: the envelope state steps when an item is accepted and the
// chosen gain is registered with the sample; stage two then multiplies, rounds,
// saturates and loads the result register. One item per cycle unless rsp_stall holds the output.
// The rate is set by the envelope state update, which must finish in the accept cycle.
// Synchronous active-high reset: envelope goes to done, gain and count to zero,
// registers to their defaults, both stages empty.
// rsp_stall holds both stages; req_stall rises only when stage one is full and stuck.
module adsr_envelope_gain #(
   parameter int SAMPLE_BITS = adsr_pkg::SampleBitsDefault,
   parameter int COUNT_BITS  = adsr_pkg::CountBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   input  logic                                req_note_start,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic [2:0]                          rsp_phase_now,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [adsr_pkg::CsrAddrW-1:0]       csr_paddr,
   input  logic [adsr_pkg::CsrDataW-1:0]       csr_pwdata,
   output logic [adsr_pkg::CsrDataW-1:0]       csr_prdata,
   output logic                                csr_pready
);

   localparam int GW = adsr_pkg::GainBits;
   localparam int PW = SAMPLE_BITS + GW + 1;   // signed product plus rounding headroom
   localparam int QW = SAMPLE_BITS + 3;        // product after the Q2.30 shift
   localparam logic signed [QW-1:0] QMAX = {4'b0000, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [QW-1:0] QMIN = {4'b1111, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [PW-1:0] HALF = PW'(1) << (adsr_pkg::GainFrac - 1);

   // ---------------- configuration registers ----------------
   logic [COUNT_BITS-1:0] attack_len_ff, decay_len_ff, sustain_len_ff;
   logic [GW-1:0]         peak_level_ff, hold_level_ff;
   logic [GW-1:0]         rise_step_ff, fall_step_ff, fade_step_ff;

   logic                    csr_write;
   adsr_pkg::csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = adsr_pkg::csr_index_type'(csr_paddr[adsr_pkg::CsrAddrW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff  <= '0;
         decay_len_ff   <= '0;
         sustain_len_ff <= '0;
         peak_level_ff  <= adsr_pkg::UnityGain;
         hold_level_ff  <= adsr_pkg::UnityGain;
         rise_step_ff   <= '0;
         fall_step_ff   <= '0;
         fade_step_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            adsr_pkg::CSR_ATTACK_SAMPLES:  attack_len_ff  <= csr_pwdata[COUNT_BITS-1:0];
            adsr_pkg::CSR_DECAY_SAMPLES:   decay_len_ff   <= csr_pwdata[COUNT_BITS-1:0];
            adsr_pkg::CSR_SUSTAIN_SAMPLES: sustain_len_ff <= csr_pwdata[COUNT_BITS-1:0];
            adsr_pkg::CSR_PEAK_LEVEL:      peak_level_ff  <= csr_pwdata[GW-1:0];
            adsr_pkg::CSR_HOLD_LEVEL:      hold_level_ff  <= csr_pwdata[GW-1:0];
            adsr_pkg::CSR_RISE_STEP:       rise_step_ff   <= csr_pwdata[GW-1:0];
            adsr_pkg::CSR_FALL_STEP:       fall_step_ff   <= csr_pwdata[GW-1:0];
            adsr_pkg::CSR_FADE_STEP:       fade_step_ff   <= csr_pwdata[GW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         adsr_pkg::CSR_ATTACK_SAMPLES:  csr_prdata = adsr_pkg::CsrDataW'(attack_len_ff);
         adsr_pkg::CSR_DECAY_SAMPLES:   csr_prdata = adsr_pkg::CsrDataW'(decay_len_ff);
         adsr_pkg::CSR_SUSTAIN_SAMPLES: csr_prdata = adsr_pkg::CsrDataW'(sustain_len_ff);
         adsr_pkg::CSR_PEAK_LEVEL:      csr_prdata = adsr_pkg::CsrDataW'(peak_level_ff);
         adsr_pkg::CSR_HOLD_LEVEL:      csr_prdata = adsr_pkg::CsrDataW'(hold_level_ff);
         adsr_pkg::CSR_RISE_STEP:       csr_prdata = adsr_pkg::CsrDataW'(rise_step_ff);
         adsr_pkg::CSR_FALL_STEP:       csr_prdata = adsr_pkg::CsrDataW'(fall_step_ff);
         adsr_pkg::CSR_FADE_STEP:       csr_prdata = adsr_pkg::CsrDataW'(fade_step_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline flow ----------------
   logic s1_valid_ff, out_valid_ff;
   logic out_move, s1_move, accept;

   assign out_move  = !out_valid_ff || !rsp_stall;
   assign s1_move   = !s1_valid_ff || out_move;
   assign req_stall = !s1_move;
   assign accept    = req_valid && s1_move;

   // ---------------- envelope state ----------------
   adsr_pkg::phase_type   phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [GW-1:0]         gain_acc_ff, gain_acc_in;
   adsr_pkg::phase_type   used_phase;
   logic [GW-1:0]         used_gain;

   always_comb begin
      adsr_pkg::phase_type   ph;
      logic [COUNT_BITS-1:0] cnt;
      logic [GW-1:0]         acc;
      logic [GW:0]           sum;

      ph  = phase_ff;
      cnt = count_ff;
      acc = gain_acc_ff;
      if (req_note_start) begin
         ph  = adsr_pkg::PH_ATTACK;
         cnt = '0;
         acc = '0;
      end
      // zero-length phases fall through on the same item
      if (ph == adsr_pkg::PH_ATTACK && cnt >= attack_len_ff) begin
         ph  = adsr_pkg::PH_DECAY;
         cnt = '0;
         acc = peak_level_ff;
      end
      if (ph == adsr_pkg::PH_DECAY && cnt >= decay_len_ff) begin
         ph  = adsr_pkg::PH_SUSTAIN;
         cnt = '0;
         acc = hold_level_ff;
      end
      if (ph == adsr_pkg::PH_SUSTAIN && cnt >= sustain_len_ff) begin
         ph  = adsr_pkg::PH_RELEASE;
         cnt = '0;
         acc = hold_level_ff;
      end

      used_phase  = ph;
      used_gain   = acc;
      phase_in    = ph;
      count_in    = cnt + COUNT_BITS'(1);
      gain_acc_in = acc;
      sum         = {1'b0, acc} + {1'b0, rise_step_ff};
      case (ph)
         adsr_pkg::PH_ATTACK: begin
            gain_acc_in = sum[GW] ? '1 : sum[GW-1:0];
         end
         adsr_pkg::PH_DECAY: begin
            gain_acc_in = (acc > fall_step_ff) ? acc - fall_step_ff : '0;
         end
         adsr_pkg::PH_SUSTAIN: begin
            gain_acc_in = acc;
         end
         adsr_pkg::PH_RELEASE: begin
            // release applies its step before use; reaching zero ends the note
            gain_acc_in = (acc > fade_step_ff) ? acc - fade_step_ff : '0;
            used_gain   = gain_acc_in;
            count_in    = cnt;
            if (gain_acc_in == '0) begin
               phase_in = adsr_pkg::PH_DONE;
            end
         end
         default: begin
            used_phase  = adsr_pkg::PH_DONE;
            phase_in    = adsr_pkg::PH_DONE;
            used_gain   = '0;
            gain_acc_in = '0;
            count_in    = cnt;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= adsr_pkg::PH_DONE;
         count_ff    <= '0;
         gain_acc_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         gain_acc_ff <= gain_acc_in;
      end
   end

   // ---------------- stage one: gain and sample ----------------
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [GW-1:0]                 s1_gain_ff;
   adsr_pkg::phase_type           s1_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample_in;
         s1_gain_ff   <= used_gain;
         s1_phase_ff  <= used_phase;
      end
   end

   // ---------------- stage two: multiply, round half up, saturate ----------------
   logic signed [PW-1:0]          prod, rounded;
   logic signed [QW-1:0]          quot;
   logic signed [SAMPLE_BITS-1:0] sat_out;

   assign prod    = PW'(s1_sample_ff) * $signed(PW'({1'b0, s1_gain_ff}));
   assign rounded = prod + HALF;
   assign quot    = rounded[PW-1:adsr_pkg::GainFrac];

   always_comb begin
      if (quot > QMAX) begin
         sat_out = QMAX[SAMPLE_BITS-1:0];
      end else if (quot < QMIN) begin
         sat_out = QMIN[SAMPLE_BITS-1:0];
      end else begin
         sat_out = quot[SAMPLE_BITS-1:0];
      end
   end

   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   adsr_pkg::phase_type           out_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_move) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_move && s1_valid_ff) begin
         out_sample_ff <= sat_out;
         out_phase_ff  <= s1_phase_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_phase_now  = out_phase_ff;

endmodule

>>> sim/adsr_envelope_checker.sv
module adsr_envelope_checker (
   input  logic                                          clock,
   input  logic                                          reset,

   input  logic                                          req_valid,
   input  logic                                          req_stall,
   input  logic signed [adsr_pkg::SampleBitsDefault-1:0] req_sample_in,
   input  logic                                          req_note_start,

   input  logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   input  logic signed [adsr_pkg::SampleBitsDefault-1:0] rsp_sample_out,
   input  logic [2:0]                                    rsp_phase_now,

   input  logic                                          csr_psel,
   input  logic                                          csr_penable,
   input  logic                                          csr_pwrite,
   input  logic [adsr_pkg::CsrAddrW-1:0]                 csr_paddr,
   input  logic [adsr_pkg::CsrDataW-1:0]                 csr_pwdata,
   input  logic [adsr_pkg::CsrDataW-1:0]                 csr_prdata,
   input  logic                                          csr_pready,

   output int                                            error_count,
   output int                                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] LengthMask = (32'd1 << adsr_pkg::CountBitsDefault) - 32'd1;

   typedef struct packed {
      logic signed [adsr_pkg::SampleBitsDefault-1:0] sample;
      adsr_pkg::phase_type                           phase;
   } gained_sample_type;

   gained_sample_type                     gained_fifo [$];
   logic [adsr_pkg::CsrDataW-1:0]         csr_copy [8];
   adsr_pkg::phase_type                   env_phase;
   logic [adsr_pkg::CountBitsDefault-1:0] env_count;
   logic [adsr_pkg::GainBits-1:0]         env_gain;
   int                                    mismatches = 0;

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      if (mismatches < 10)
         $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      mismatches++;
   endfunction

   // round half up, then clamp to the sample range
   function automatic logic signed [adsr_pkg::SampleBitsDefault-1:0] scaled_sample(
      input logic signed [adsr_pkg::SampleBitsDefault-1:0] s,
      input logic [adsr_pkg::GainBits-1:0] g);
      logic signed [63:0] prod;
      prod = 64'(s) * $signed({32'd0, g}) + (64'sd1 <<< (adsr_pkg::GainFrac - 1));
      prod = prod >>> adsr_pkg::GainFrac;
      if (prod > 64'sd32767)
         return 16'h7FFF;
      if (prod < -64'sd32768)
         return 16'h8000;
      return prod[adsr_pkg::SampleBitsDefault-1:0];
   endfunction

   function automatic gained_sample_type envelope_advance(
      input logic signed [adsr_pkg::SampleBitsDefault-1:0] s, input logic start);
      gained_sample_type                  res;
      logic [adsr_pkg::GainBits:0]   sum;
      logic [adsr_pkg::GainBits-1:0] g;
      g = '0;
      if (start) begin
         env_phase = adsr_pkg::PH_ATTACK;
         env_count = '0;
         env_gain  = '0;
      end
      // zero-length phases fall through on the same item
      if (env_phase == adsr_pkg::PH_ATTACK &&
          32'(env_count) >= csr_copy[adsr_pkg::CSR_ATTACK_SAMPLES]) begin
         env_phase = adsr_pkg::PH_DECAY;
         env_count = '0;
         env_gain  = csr_copy[adsr_pkg::CSR_PEAK_LEVEL];
      end
      if (env_phase == adsr_pkg::PH_DECAY &&
          32'(env_count) >= csr_copy[adsr_pkg::CSR_DECAY_SAMPLES]) begin
         env_phase = adsr_pkg::PH_SUSTAIN;
         env_count = '0;
         env_gain  = csr_copy[adsr_pkg::CSR_HOLD_LEVEL];
      end
      if (env_phase == adsr_pkg::PH_SUSTAIN &&
          32'(env_count) >= csr_copy[adsr_pkg::CSR_SUSTAIN_SAMPLES]) begin
         env_phase = adsr_pkg::PH_RELEASE;
         env_count = '0;
         env_gain  = csr_copy[adsr_pkg::CSR_HOLD_LEVEL];
      end
      res.phase = env_phase;
      case (env_phase)
         adsr_pkg::PH_ATTACK: begin
            g         = env_gain;
            sum       = {1'b0, env_gain} + {1'b0, csr_copy[adsr_pkg::CSR_RISE_STEP]};
            env_gain  = sum[adsr_pkg::GainBits] ? '1 : sum[adsr_pkg::GainBits-1:0];
            env_count = env_count + adsr_pkg::CountBitsDefault'(1);
         end
         adsr_pkg::PH_DECAY: begin
            g         = env_gain;
            env_gain  = (env_gain > csr_copy[adsr_pkg::CSR_FALL_STEP]) ?
                        env_gain - csr_copy[adsr_pkg::CSR_FALL_STEP] : '0;
            env_count = env_count + adsr_pkg::CountBitsDefault'(1);
         end
         adsr_pkg::PH_SUSTAIN: begin
            g         = env_gain;
            env_count = env_count + adsr_pkg::CountBitsDefault'(1);
         end
         adsr_pkg::PH_RELEASE: begin
            // release reports the step that reaches zero, then goes done
            env_gain = (env_gain > csr_copy[adsr_pkg::CSR_FADE_STEP]) ?
                       env_gain - csr_copy[adsr_pkg::CSR_FADE_STEP] : '0;
            g        = env_gain;
            if (env_gain == '0)
               env_phase = adsr_pkg::PH_DONE;
         end
         default: begin
            res.phase = adsr_pkg::PH_DONE;
            env_phase = adsr_pkg::PH_DONE;
            env_gain  = '0;
         end
      endcase
      res.sample = scaled_sample(s, g);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      gained_sample_type       want;
      adsr_pkg::csr_index_type idx;
      if (reset) begin
         env_phase = adsr_pkg::PH_DONE;
         env_count = '0;
         env_gain  = '0;
         foreach (csr_copy[i])
            csr_copy[i] = '0;
         csr_copy[adsr_pkg::CSR_PEAK_LEVEL] = adsr_pkg::UnityGain;
         csr_copy[adsr_pkg::CSR_HOLD_LEVEL] = adsr_pkg::UnityGain;
         gained_fifo.delete();
      end else begin
         // a result never leaves in the same cycle as its item, so pop first
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (gained_fifo.size() == 0) begin
               note_mismatch("unexpected item, sample_out", 0, rsp_sample_out);
            end else begin
               want = gained_fifo.pop_front();
               if (rsp_sample_out !== want.sample)
                  note_mismatch("sample_out", want.sample, rsp_sample_out);
               if (rsp_phase_now !== want.phase)
                  note_mismatch("phase_now", want.phase, rsp_phase_now);
            end
         end
         if (csr_psel === 1'b1 && csr_penable === 1'b1 && csr_pready === 1'b1) begin
            idx = adsr_pkg::csr_index_type'(csr_paddr[4:2]);
            if (csr_pwrite === 1'b1)
               csr_copy[idx] = (idx <= adsr_pkg::CSR_SUSTAIN_SAMPLES) ?
                               (csr_pwdata & LengthMask) : csr_pwdata;
            else if (csr_prdata !== csr_copy[idx])
               note_mismatch("register readback", csr_copy[idx], csr_prdata);
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            gained_fifo.push_back(envelope_advance(req_sample_in, req_note_start));
      end
      pending_count <= gained_fifo.size();
      error_count   <= mismatches;
   end

endmodule

>>> sim/adsr_envelope_gain_tb.sv
module adsr_envelope_gain_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // generous cycle budget for the whole run
   localparam int RunLimit     = 200000;
   localparam int HoldStretch  = 300;    // long output hold to back up the pipe
   localparam int PhaseCount   = 12;
   localparam int PhaseItems   = 90;
   localparam int DrainCycles  = 8;      // two-stage pipe, plus margin

   // register setting families
   typedef enum {
      CFG_RANDOM,    // short phases, random levels and steps
      CFG_DIRECTED,  // fixed values that hit both saturations
      CFG_TOP,       // every register all ones
      CFG_ZERO,      // every register zero
      CFG_HELD       // zero fade step: release holds the sustain level
   } setting_kind_type;

   logic                                          clock;
   logic                                          reset;
   logic                                          req_valid;
   logic                                          req_stall;
   logic signed [adsr_pkg::SampleBitsDefault-1:0] req_sample_in;
   logic                                          req_note_start;
   logic                                          rsp_valid;
   logic                                          rsp_stall;
   logic signed [adsr_pkg::SampleBitsDefault-1:0] rsp_sample_out;
   logic [2:0]                                    rsp_phase_now;
   logic                                          csr_psel;
   logic                                          csr_penable;
   logic                                          csr_pwrite;
   logic [adsr_pkg::CsrAddrW-1:0]                 csr_paddr;
   logic [adsr_pkg::CsrDataW-1:0]                 csr_pwdata;
   logic [adsr_pkg::CsrDataW-1:0]                 csr_prdata;
   logic                                          csr_pready;

   int error_count;
   int pending_count;

   int idle_pct;        // chance per cycle that the sender idles
   int stall_pct;       // chance per cycle that the receiver stalls
   bit hold_request;    // asks the receiver process for one long hold
   int hold_left;
   int items_sent;
   int settings_used;
   int cycle_count;

   adsr_envelope_gain dut (.*);

   adsr_envelope_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: only reached if the run hangs (lost or stuck items).
   initial begin
      cycle_count = 0;
      while (cycle_count < RunLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("adsr_envelope_gain_tb failed");
      $finish;
   end

   // Receiver: random stalls per the current mode; a long hold when asked,
   // counted here so the sender keeps pushing while outputs are blocked.
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HoldStretch;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // One APB transfer: setup cycle, then access until pready.
   // Leaves psel up so transfers can run back to back.
   task automatic csr_access(input adsr_pkg::csr_index_type idx, input logic wr,
                             input logic [adsr_pkg::CsrDataW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
   endtask

   function automatic logic [adsr_pkg::CsrDataW-1:0] setting_value(
      input setting_kind_type kind, input adsr_pkg::csr_index_type idx);
      logic [adsr_pkg::CsrDataW-1:0] v;
      logic                          is_length;
      is_length = (idx <= adsr_pkg::CSR_SUSTAIN_SAMPLES);
      case (kind)
         CFG_TOP:  v = '1;
         CFG_ZERO: v = '0;
         CFG_DIRECTED: begin
            // attack overflows, decay underflows, release ends at zero
            case (idx)
               adsr_pkg::CSR_ATTACK_SAMPLES:  v = 32'd2;
               adsr_pkg::CSR_DECAY_SAMPLES:   v = 32'd2;
               adsr_pkg::CSR_SUSTAIN_SAMPLES: v = 32'd1;
               adsr_pkg::CSR_HOLD_LEVEL:      v = adsr_pkg::UnityGain;
               adsr_pkg::CSR_FADE_STEP:       v = 32'h2000_0000;
               default:                       v = '1;
            endcase
         end
         default: begin
            if (is_length) begin
               // short phases so a note walks through all of them;
               // junk in the top byte must be dropped
               v = $urandom_range(0, 10);
               if ($urandom_range(0, 2) == 0)
                  v = v | ($urandom & 32'hFF00_0000);
            end else if (idx == adsr_pkg::CSR_PEAK_LEVEL ||
                         idx == adsr_pkg::CSR_HOLD_LEVEL) begin
               case ($urandom_range(0, 3))
                  0:       v = $urandom;
                  1:       v = adsr_pkg::UnityGain;
                  2:       v = '1;
                  default: v = $urandom >> $urandom_range(0, 31);
               endcase
            end else begin
               case ($urandom_range(0, 7))
                  0:       v = '0;
                  1:       v = '1;
                  default: v = $urandom >> $urandom_range(1, 6);
               endcase
            end
            if (kind == CFG_HELD && idx == adsr_pkg::CSR_FADE_STEP)
               v = '0;
            if (kind == CFG_HELD && idx == adsr_pkg::CSR_HOLD_LEVEL && v == '0)
               v = adsr_pkg::UnityGain;
         end
      endcase
      return v;
   endfunction

   // Write all eight registers, then read them all back for the checker.
   task automatic load_setting(input setting_kind_type kind);
      for (int i = 0; i < 8; i++)
         csr_access(adsr_pkg::csr_index_type'(i), 1'b1,
                    setting_value(kind, adsr_pkg::csr_index_type'(i)));
      for (int i = 0; i < 8; i++)
         csr_access(adsr_pkg::csr_index_type'(i), 1'b0, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_used++;
   endtask

   // Offer one item after any random idle cycles, return once it is taken.
   task automatic send_item(input logic signed [adsr_pkg::SampleBitsDefault-1:0] smp,
                            input logic start);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample_in  <= smp;
      req_note_start <= start;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
   endtask

   // Stop offering and wait until every expected item has come out.
   // The first wait lets the checker see the last accepted item.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic signed [adsr_pkg::SampleBitsDefault-1:0] pick_sample();
      case ($urandom_range(0, 15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         default: return adsr_pkg::SampleBitsDefault'($urandom);
      endcase
   endfunction

   // Mostly well-formed notes: start flag on the first item, random body.
   // Some notes lose their start flag, a few get a restart mid-note.
   task automatic send_notes(input int count);
      int  left;
      int  len;
      logic start;
      left = count;
      while (left > 0) begin
         len = $urandom_range(1, 40);
         for (int i = 0; i < len && left > 0; i++) begin
            if (i == 0)
               start = ($urandom_range(0, 19) != 0);
            else
               start = ($urandom_range(0, 49) == 0);
            send_item(pick_sample(), start);
            left--;
         end
      end
   endtask

   initial begin
      setting_kind_type kind;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample_in  = '0;
      req_note_start = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      hold_request   = 1'b0;
      items_sent     = 0;
      settings_used  = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings: done before any note, then a note with all
      // lengths zero skips straight to release and holds unity (no fade).
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sh8000, 1'b1);
      send_item(16'sh7FFF, 1'b0);
      send_item(-16'sd1, 1'b0);
      send_item(16'sd1, 1'b0);

      // Directed, saturating setting: gain overflow in attack, output clamp
      // both ways, decay underflow, sustain, release reaching zero, done.
      drain_results();
      load_setting(CFG_DIRECTED);
      send_item(16'sh7FFF, 1'b1);
      send_item(16'sh8000, 1'b0);
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sh8000, 1'b0);
      send_item(16'sd12345, 1'b0);
      send_item(16'sh8000, 1'b0);
      send_item(-16'sd3, 1'b0);
      send_item(16'sd7, 1'b0);
      send_item(16'sh7FFF, 1'b0);
      // restart in the middle of a note
      send_item(-16'sd1, 1'b1);
      send_item(16'sh7FFF, 1'b1);

      // Random phases: a fresh setting each, cycling through the idle and stall modes.
      for (int ph = 0; ph < PhaseCount; ph++) begin
         drain_results();
         case (ph)
            2:       kind = CFG_TOP;
            6:       kind = CFG_ZERO;
            9:       kind = CFG_HELD;
            default: kind = CFG_RANDOM;
         endcase
         load_setting(kind);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         // back up the pipe once while the sender streams without gaps
         if (ph == 4)
            hold_request = 1'b1;
         send_notes(PhaseItems);
      end

      drain_results();
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d samples over %0d register settings: all envelope phases,",
               items_sent, settings_used);
      $display("gain and output saturation, skipped phases, held release, long output hold");
      if (error_count == 0)
         $display("adsr_envelope_gain_tb passed");
      else
         $display("adsr_envelope_gain_tb failed");
      $finish;
   end

endmodule
